// File: hw/rtl/tsts_pkg.sv
package tsts_pkg;

   localparam int MaxTasksDefault = 8;

   localparam int TickW  = 32;
   localparam int PrioW  = 8;
   localparam int TaskW  = 3;
   localparam int MaskW  = 8;
   localparam int SliceW = 8;

   localparam logic [SliceW-1:0] SliceReset = SliceW'(5);

   localparam logic OpTick  = 1'b0;
   localparam logic OpSleep = 1'b1;

   // controller to datapath
   typedef struct packed {
      logic load;       // request taken, latch fields
      logic sleep_wr;   // store wake time and priority
      logic scan_rd;    // read one timer entry, step the scan
      logic slice_upd;  // count down the current slice
      logic rsp_load;   // move the result into the output register
   } tsts_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic op_sleep;
      logic scan_last;
   } tsts_sts_type;

endpackage

// File: hw/rtl/task_sleep_timer_and_slice_scheduler.sv
// tick request: latched, decoded, every timer entry scanned, drained, slice counted down;
// sleep request: latched, decoded, wake time written; both then wait for a free output register
// one request at a time: the next one is taken once the result is loaded and the sequencer is idle;
// the scan reads one entry a cycle
// a finished result waits in the output register while the next request is taken
// reset: synchronous, active high; tick counter zero, no task sleeping, slices and reload at five
module task_sleep_timer_and_slice_scheduler
   import tsts_pkg::*;
#(
   parameter int MAX_TASKS = MaxTasksDefault
) (
   input  logic              clock,
   input  logic              reset,
   // request channel
   input  logic              req_valid,
   output logic              req_stall,
   input  logic              req_operation,
   input  logic [TaskW-1:0]  req_sleep_task,
   input  logic [TickW-1:0]  req_sleep_ticks,
   input  logic [PrioW-1:0]  req_sleep_priority,
   input  logic              req_current_valid,
   input  logic              req_current_running,
   input  logic [TaskW-1:0]  req_current_task,
   input  logic [PrioW-1:0]  req_current_priority,
   // result channel
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [MaskW-1:0]  rsp_woken_mask,
   output logic              rsp_switch_request,
   output logic [TickW-1:0]  rsp_tick_now,
   // slice reload register
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [SliceW-1:0] csr_slice_reload
);

   tsts_cmd_type cmd;
   tsts_sts_type sts;

   // the user must write the register only while idle; the block does not enforce it, and the port never pushes back
   assign csr_ready = 1'b1;

   // sequencer: accept, branch on operation, sleep write or timer scan,
   // slice count-down, then hand the result to the output register
   tsts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // tick counter, waiting flags, timer memories and the result register
   tsts_dp #(
      .MAX_TASKS (MAX_TASKS)
   ) u_dp (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .sts                  (sts),
      .req_operation        (req_operation),
      .req_sleep_task       (req_sleep_task),
      .req_sleep_ticks      (req_sleep_ticks),
      .req_sleep_priority   (req_sleep_priority),
      .req_current_valid    (req_current_valid),
      .req_current_running  (req_current_running),
      .req_current_task     (req_current_task),
      .req_current_priority (req_current_priority),
      .csr_write            (csr_valid && csr_ready),
      .csr_slice_reload     (csr_slice_reload),
      .rsp_woken_mask       (rsp_woken_mask),
      .rsp_switch_request   (rsp_switch_request),
      .rsp_tick_now         (rsp_tick_now)
   );

endmodule

// File: hw/rtl/tsts_ctrl.sv
module tsts_ctrl
   import tsts_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   input  tsts_sts_type sts,
   output tsts_cmd_type cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_SLEEP,
      ST_SCAN,
      ST_DRAIN,
      ST_SLICE,
      ST_FINISH
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_free;

   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_DECODE;
            end
         end
         // the operation is only known once latched
         ST_DECODE: begin
            state_in = sts.op_sleep ? ST_SLEEP : ST_SCAN;
         end
         ST_SLEEP: begin
            cmd.sleep_wr = 1'b1;
            state_in     = ST_FINISH;
         end
         ST_SCAN: begin
            cmd.scan_rd = 1'b1;
            if (sts.scan_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_SLICE;
         end
         ST_SLICE: begin
            cmd.slice_upd = 1'b1;
            state_in      = ST_FINISH;
         end
         ST_FINISH: begin
            if (rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (cmd.rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

`ifndef SYNTHESIS
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> !(rsp_valid_ff && rsp_stall))
      else $error("result overwritten while still pending");

   a_one_action: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.sleep_wr, cmd.scan_rd, cmd.slice_upd, cmd.rsp_load}))
      else $error("more than one datapath action in a cycle");

   a_scan_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN && sts.scan_last) |=> (state_ff == ST_DRAIN))
      else $error("scan did not end after the last entry");
`endif

endmodule

// File: hw/rtl/tsts_dp.sv
module tsts_dp
   import tsts_pkg::*;
#(
   parameter int MAX_TASKS = MaxTasksDefault
) (
   input  logic              clock,
   input  logic              reset,
   input  tsts_cmd_type      cmd,
   output tsts_sts_type      sts,
   input  logic              req_operation,
   input  logic [TaskW-1:0]  req_sleep_task,
   input  logic [TickW-1:0]  req_sleep_ticks,
   input  logic [PrioW-1:0]  req_sleep_priority,
   input  logic              req_current_valid,
   input  logic              req_current_running,
   input  logic [TaskW-1:0]  req_current_task,
   input  logic [PrioW-1:0]  req_current_priority,
   input  logic              csr_write,
   input  logic [SliceW-1:0] csr_slice_reload,
   output logic [MaskW-1:0]  rsp_woken_mask,
   output logic              rsp_switch_request,
   output logic [TickW-1:0]  rsp_tick_now
);

   localparam int TW = $clog2(MAX_TASKS);

   // latched request
   logic              op_ff;
   logic [TaskW-1:0]  sleep_task_ff;
   logic [TickW-1:0]  sleep_ticks_ff;
   logic [PrioW-1:0]  sleep_prio_ff;
   logic              cur_valid_ff;
   logic              cur_running_ff;
   logic [TaskW-1:0]  cur_task_ff;
   logic [PrioW-1:0]  cur_prio_ff;

   logic [TickW-1:0]  tick_ff;
   logic [SliceW-1:0] slice_reload_ff;
   logic [MAX_TASKS-1:0] waiting_ff;
   logic [MAX_TASKS-1:0] slice_vld_ff;

   logic [TickW-1:0]  wake_mem [MAX_TASKS];
   logic [PrioW-1:0]  prio_mem [MAX_TASKS];
   logic [SliceW-1:0] slice_mem [MAX_TASKS];

   logic [TW-1:0]     scan_ff;
   logic              eval_vld_ff;
   logic [TW-1:0]     eval_idx_ff;
   logic [TickW-1:0]  wake_rd_ff;
   logic [PrioW-1:0]  prio_rd_ff;
   logic [SliceW-1:0] slice_rd_ff;

   logic [MaskW-1:0]  mask_ff;
   logic              sw_ff;
   logic [MaskW-1:0]  mask_out_ff;
   logic              sw_out_ff;
   logic [TickW-1:0]  tick_out_ff;

   logic [TW-1:0]     sleep_idx;
   logic              sleep_ok;
   logic [TW-1:0]     slice_idx;
   logic              slice_act;
   logic              wake_hit;
   logic [SliceW-1:0] slice_cur;
   logic [SliceW-1:0] slice_dec;
   logic              slice_wrap;

   assign sleep_idx = TW'(sleep_task_ff);
   assign sleep_ok  = (int'(sleep_task_ff) < MAX_TASKS);
   assign slice_idx = TW'(cur_task_ff);
   assign slice_act = cur_valid_ff && cur_running_ff && (int'(cur_task_ff) < MAX_TASKS);

   assign wake_hit = eval_vld_ff && waiting_ff[eval_idx_ff] && (wake_rd_ff <= tick_ff);

   assign slice_cur  = slice_vld_ff[slice_idx] ? slice_rd_ff : SliceReset;
   assign slice_dec  = (slice_cur != '0) ? slice_cur - SliceW'(1) : '0;
   assign slice_wrap = (slice_dec == '0);

   assign sts.op_sleep  = (op_ff == OpSleep);
   assign sts.scan_last = (scan_ff == TW'(MAX_TASKS - 1));

   assign rsp_woken_mask     = mask_out_ff;
   assign rsp_switch_request = sw_out_ff;
   assign rsp_tick_now       = tick_out_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff          <= req_operation;
         sleep_task_ff  <= req_sleep_task;
         sleep_ticks_ff <= req_sleep_ticks;
         sleep_prio_ff  <= req_sleep_priority;
         cur_valid_ff   <= req_current_valid;
         cur_running_ff <= req_current_running;
         cur_task_ff    <= req_current_task;
         cur_prio_ff    <= req_current_priority;
      end
      if (cmd.rsp_load) begin
         mask_out_ff <= mask_ff;
         sw_out_ff   <= sw_ff;
         tick_out_ff <= tick_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff         <= '0;
         slice_reload_ff <= SliceReset;
         waiting_ff      <= '0;
         slice_vld_ff    <= '0;
         scan_ff         <= '0;
         eval_vld_ff     <= 1'b0;
      end else begin
         if (csr_write) begin
            slice_reload_ff <= csr_slice_reload;
         end
         if (cmd.load && req_operation == OpTick) begin
            tick_ff <= tick_ff + TickW'(1);
         end
         if (cmd.load) begin
            scan_ff <= '0;
         end else if (cmd.scan_rd) begin
            scan_ff <= sts.scan_last ? '0 : scan_ff + TW'(1);
         end
         eval_vld_ff <= cmd.scan_rd;
         if (cmd.sleep_wr && sleep_ok) begin
            waiting_ff[sleep_idx] <= 1'b1;
         end
         if (wake_hit) begin
            waiting_ff[eval_idx_ff] <= 1'b0;
         end
         if (cmd.slice_upd && slice_act) begin
            slice_vld_ff[slice_idx] <= 1'b1;
         end
      end
   end

   // result accumulation
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mask_ff <= '0;
         sw_ff   <= 1'b0;
      end else begin
         if (cmd.sleep_wr) begin
            sw_ff <= 1'b1;
         end
         if (wake_hit) begin
            mask_ff <= mask_ff | (MaskW'(1) << eval_idx_ff);
            if (cur_valid_ff && prio_rd_ff > cur_prio_ff) begin
               sw_ff <= 1'b1;
            end
         end
         if (cmd.slice_upd && slice_act && slice_wrap) begin
            sw_ff <= 1'b1;
         end
      end
   end

   // timer and slice memories
   always_ff @(posedge clock) begin
      if (cmd.sleep_wr && sleep_ok) begin
         wake_mem[sleep_idx] <= tick_ff + sleep_ticks_ff;
         prio_mem[sleep_idx] <= sleep_prio_ff;
      end
      if (cmd.slice_upd && slice_act) begin
         slice_mem[slice_idx] <= slice_wrap ? slice_reload_ff : slice_dec;
      end
      wake_rd_ff  <= wake_mem[scan_ff];
      prio_rd_ff  <= prio_mem[scan_ff];
      slice_rd_ff <= slice_mem[slice_idx];
      eval_idx_ff <= scan_ff;
   end

endmodule

// File: dv/sleep_slice_checker.sv
`timescale 1ns / 100ps
module sleep_slice_checker
   import tsts_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  logic              req_operation,
   input  logic [TaskW-1:0]  req_sleep_task,
   input  logic [TickW-1:0]  req_sleep_ticks,
   input  logic [PrioW-1:0]  req_sleep_priority,
   input  logic              req_current_valid,
   input  logic              req_current_running,
   input  logic [TaskW-1:0]  req_current_task,
   input  logic [PrioW-1:0]  req_current_priority,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  logic [MaskW-1:0]  rsp_woken_mask,
   input  logic              rsp_switch_request,
   input  logic [TickW-1:0]  rsp_tick_now,
   input  logic              csr_valid,
   input  logic              csr_ready,
   input  logic [SliceW-1:0] csr_slice_reload,
   output int                mismatches,
   output int                outstanding
);

   localparam int NumTasks = MaxTasksDefault;

   typedef struct packed {
      logic [MaskW-1:0] woken;
      logic             want_switch;
      logic [TickW-1:0] tick;
   } sched_result_type;

   logic [TickW-1:0]  model_tick;
   logic              asleep       [NumTasks];
   logic [TickW-1:0]  wake_at      [NumTasks];
   logic [PrioW-1:0]  sleeper_prio [NumTasks];
   logic [SliceW-1:0] slice_count  [NumTasks];
   logic [SliceW-1:0] reload_value;
   sched_result_type  awaited_results [$];

   // state update and result of one accepted request
   task automatic advance_scheduler(output sched_result_type res);
      sched_result_type r;
      r = '0;
      if (req_operation == OpSleep) begin
         wake_at[req_sleep_task]      = model_tick + req_sleep_ticks;
         sleeper_prio[req_sleep_task] = req_sleep_priority;
         asleep[req_sleep_task]       = 1'b1;
         r.want_switch                = 1'b1;
      end else begin
         model_tick = model_tick + TickW'(1);
         for (int i = 0; i < NumTasks; i++) begin
            if (asleep[i] && wake_at[i] <= model_tick) begin
               asleep[i]  = 1'b0;
               wake_at[i] = '0;
               if (i < MaskW) r.woken[i] = 1'b1;
               if (req_current_valid && sleeper_prio[i] > req_current_priority)
                  r.want_switch = 1'b1;
            end
         end
         // slice of the running task
         if (req_current_valid && req_current_running && req_current_task < NumTasks) begin
            if (slice_count[req_current_task] != '0)
               slice_count[req_current_task] = slice_count[req_current_task] - SliceW'(1);
            if (slice_count[req_current_task] == '0) begin
               slice_count[req_current_task] = reload_value;
               r.want_switch = 1'b1;
            end
         end
      end
      r.tick = model_tick;
      res = r;
   endtask

   always @(posedge clock) begin
      sched_result_type got;
      sched_result_type want;
      if (reset) begin
         model_tick   = '0;
         reload_value = SliceReset;
         for (int i = 0; i < NumTasks; i++) begin
            asleep[i]       = 1'b0;
            wake_at[i]      = '0;
            sleeper_prio[i] = '0;
            slice_count[i]  = SliceReset;
         end
         awaited_results.delete();
         mismatches = 0;
      end else begin
         if (csr_valid && csr_ready) reload_value = csr_slice_reload;
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_woken_mask, rsp_switch_request, rsp_tick_now};
            if (awaited_results.size() == 0) begin
               $error("result with no request outstanding: mask %0h switch %0b tick %0h",
                      got.woken, got.want_switch, got.tick);
               mismatches++;
            end else begin
               want = awaited_results.pop_front();
               if (got.woken !== want.woken) begin
                  $error("woken_mask: expected %0h, got %0h", want.woken, got.woken);
                  mismatches++;
               end
               if (got.want_switch !== want.want_switch) begin
                  $error("switch_request: expected %0b, got %0b",
                         want.want_switch, got.want_switch);
                  mismatches++;
               end
               if (got.tick !== want.tick) begin
                  $error("tick_now: expected %0h, got %0h", want.tick, got.tick);
                  mismatches++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            advance_scheduler(want);
            awaited_results.push_back(want);
         end
      end
      outstanding = awaited_results.size();
   end

endmodule

// File: dv/tb_task_sleep_timer_and_slice_scheduler.sv
`timescale 1ns / 100ps
module tb_task_sleep_timer_and_slice_scheduler;
   import tsts_pkg::*;

   // no handshake on any channel for this long means the block has hung
   localparam int WatchdogLimit = 2000;
   // drain after the last result: longer than a tick scan plus margin
   localparam int DrainCycles   = 2 * MaxTasksDefault + 10;
   localparam int NumPhases     = 8;
   localparam int PhaseItems    = 105;

   logic              clock                = 1'b0;
   logic              reset                = 1'b1;
   logic              req_valid            = 1'b0;
   logic              req_stall;
   logic              req_operation        = OpTick;
   logic [TaskW-1:0]  req_sleep_task       = '0;
   logic [TickW-1:0]  req_sleep_ticks      = '0;
   logic [PrioW-1:0]  req_sleep_priority   = '0;
   logic              req_current_valid    = 1'b0;
   logic              req_current_running  = 1'b0;
   logic [TaskW-1:0]  req_current_task     = '0;
   logic [PrioW-1:0]  req_current_priority = '0;
   logic              rsp_valid;
   logic              rsp_stall            = 1'b0;
   logic [MaskW-1:0]  rsp_woken_mask;
   logic              rsp_switch_request;
   logic [TickW-1:0]  rsp_tick_now;
   logic              csr_valid            = 1'b0;
   logic              csr_ready;
   logic [SliceW-1:0] csr_slice_reload     = '0;

   int mismatches;
   int outstanding;
   int send_idle_pct = 0;
   int stall_pct     = 0;
   int idle_cycles   = 0;
   int tick_reqs     = 0;
   int sleep_reqs    = 0;

   // reload per phase: the extremes zero (every running tick switches) and 255, plus 1, 2, 3, 7 and 128
   logic [SliceW-1:0] reload_plan [NumPhases] = '{8'd1, 8'd255, 8'd0, 8'd3,
                                                  8'd2, 8'd7, 8'd0, 8'd128};

   task_sleep_timer_and_slice_scheduler #(
      .MAX_TASKS (MaxTasksDefault)
   ) i_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_operation        (req_operation),
      .req_sleep_task       (req_sleep_task),
      .req_sleep_ticks      (req_sleep_ticks),
      .req_sleep_priority   (req_sleep_priority),
      .req_current_valid    (req_current_valid),
      .req_current_running  (req_current_running),
      .req_current_task     (req_current_task),
      .req_current_priority (req_current_priority),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_woken_mask       (rsp_woken_mask),
      .rsp_switch_request   (rsp_switch_request),
      .rsp_tick_now         (rsp_tick_now),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_slice_reload     (csr_slice_reload)
   );

   sleep_slice_checker i_checker (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_operation        (req_operation),
      .req_sleep_task       (req_sleep_task),
      .req_sleep_ticks      (req_sleep_ticks),
      .req_sleep_priority   (req_sleep_priority),
      .req_current_valid    (req_current_valid),
      .req_current_running  (req_current_running),
      .req_current_task     (req_current_task),
      .req_current_priority (req_current_priority),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_woken_mask       (rsp_woken_mask),
      .rsp_switch_request   (rsp_switch_request),
      .rsp_tick_now         (rsp_tick_now),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_slice_reload     (csr_slice_reload),
      .mismatches           (mismatches),
      .outstanding          (outstanding)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // receiver back-pressure, redrawn every cycle at the falling edge
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   // watchdog: any accepted request, result or register write restarts the count
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == WatchdogLimit) begin
         $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
                  WatchdogLimit, outstanding);
         $display("Mismatches found");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // drives one request from a falling edge and returns at the falling edge after acceptance;
   // valid stays high into the next request unless a sender gap is drawn
   task automatic send_request(input logic op, input logic [TaskW-1:0] stask,
                               input logic [TickW-1:0] sticks, input logic [PrioW-1:0] sprio,
                               input logic cvalid, input logic crun,
                               input logic [TaskW-1:0] ctask, input logic [PrioW-1:0] cprio);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid            <= 1'b1;
      req_operation        <= op;
      req_sleep_task       <= stask;
      req_sleep_ticks      <= sticks;
      req_sleep_priority   <= sprio;
      req_current_valid    <= cvalid;
      req_current_running  <= crun;
      req_current_task     <= ctask;
      req_current_priority <= cprio;
      do begin
         @(posedge clock);
      end while (req_stall);
      @(negedge clock);
      if (op == OpSleep) sleep_reqs++;
      else tick_reqs++;
   endtask

   // fields that the operation ignores still carry random values
   task automatic sleep_req(input logic [TaskW-1:0] t, input logic [TickW-1:0] delay,
                            input logic [PrioW-1:0] prio);
      send_request(OpSleep, t, delay, prio, 1'($urandom), 1'($urandom),
                   TaskW'($urandom), PrioW'($urandom));
   endtask

   task automatic tick_req(input logic cvalid, input logic crun,
                           input logic [TaskW-1:0] ctask, input logic [PrioW-1:0] cprio);
      send_request(OpTick, TaskW'($urandom), $urandom, PrioW'($urandom),
                   cvalid, crun, ctask, cprio);
   endtask

   // mostly short delays so tasks keep waking; some huge and some wrapping ones
   task automatic random_request();
      logic [TickW-1:0] delay;
      int pick;
      pick = $urandom_range(99);
      if ($urandom_range(99) < 30) begin
         if (pick < 75) delay = $urandom_range(12);
         else if (pick < 88) delay = $urandom;
         else delay = 32'hFFFF_FFFF - $urandom_range(3);
         sleep_req(TaskW'($urandom_range(7)), delay, PrioW'($urandom_range(255)));
      end else begin
         tick_req($urandom_range(99) < 85, $urandom_range(99) < 85,
                  TaskW'($urandom_range(7)), PrioW'($urandom_range(255)));
      end
   endtask

   // register write once every result is back; each request has a result, so no extra wait
   task automatic write_reload(input logic [SliceW-1:0] value);
      while (outstanding != 0) @(negedge clock);
      csr_valid        <= 1'b1;
      csr_slice_reload <= value;
      do begin
         @(posedge clock);
      end while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed part, reset reload of five, no idling
      tick_req(1'b0, 1'b0, 3'd0, 8'd0);              // tick with no current task
      sleep_req(3'd0, 32'd0, 8'd255);                // zero delay, strongest priority
      sleep_req(3'd7, 32'hFFFF_FFFF, 8'd0);          // delay wraps below the counter
      sleep_req(3'd3, 32'd2, 8'd200);
      sleep_req(3'd5, 32'h8000_0000, 8'd128);        // far future, stays asleep
      tick_req(1'b1, 1'b1, 3'd0, 8'd0);              // two wake, stronger one forces a switch
      tick_req(1'b0, 1'b1, 3'd2, 8'd0);              // wake with no current task, no switch
      sleep_req(3'd1, 32'd1, 8'd10);
      tick_req(1'b1, 1'b0, 3'd2, 8'd10);             // equal priority and not running
      repeat (5) tick_req(1'b1, 1'b1, 3'd6, 8'd255); // slice runs out on the fifth
      sleep_req(3'd2, 32'd0, 8'd255);
      tick_req(1'b1, 1'b1, 3'd7, 8'd255);            // woken task only equals the current one
      sleep_req(3'd4, 32'd0, 8'd1);
      tick_req(1'b1, 1'b1, 3'd4, 8'd0);              // weakest priority still outranks zero
      sleep_req(3'd6, 32'd3, 8'd0);
      sleep_req(3'd6, 32'd1, 8'd9);                  // second sleep overwrites the first
      tick_req(1'b1, 1'b1, 3'd1, 8'd8);

      // random phases, each with its own reload and idle mix
      for (int p = 0; p < NumPhases; p++) begin
         req_valid <= 1'b0;
         write_reload(reload_plan[p]);
         case (p % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 67; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 67; end
            default: begin send_idle_pct = 11; stall_pct = 11; end
         endcase
         for (int n = 0; n < PhaseItems; n++) random_request();
      end

      req_valid     <= 1'b0;
      send_idle_pct  = 0;
      stall_pct      = 0;
      while (outstanding != 0) @(negedge clock);
      repeat (DrainCycles) @(negedge clock);

      $display("run: %0d tick and %0d sleep requests, %0d slice reload settings incl. 0 and 255,",
               tick_reqs, sleep_reqs, NumPhases + 1);
      $display("     sender gaps and receiver back-pressure mixed in alternate phases");
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
